[rtl/core/xpfec_pkg.sv]
// ----------------------------------------------------------------------------
// xpfec_pkg
// Shared types and constants for the xor parity fec encoder
// ----------------------------------------------------------------------------
package xpfec_pkg;

    localparam int MAX_PAYLOAD_DEF = 2048;
    localparam int MAX_GROUP_DEF   = 16;

    localparam int CMD_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int RINDEX_W    = 11;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int GROUP_REG_W = 5;
    localparam int PAYLD_REG_W = 12;

    localparam logic [GROUP_REG_W-1:0] GROUP_RST = GROUP_REG_W'(2);
    localparam logic [PAYLD_REG_W-1:0] PAYLD_RST = PAYLD_REG_W'(2048);

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE  = 2'd0,
        REG_GROUP   = 2'd1,
        REG_PAYLOAD = 2'd2,
        REG_UNUSED  = 2'd3
    } reg_idx_t;

endpackage

[rtl/core/xpfec_if.sv]
// ----------------------------------------------------------------------------
// xpfec_if
// Channel interfaces: request, result and configuration write
// ----------------------------------------------------------------------------
interface xpfec_req_if
    import xpfec_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [BYTE_W-1:0]   data_byte;
    logic                end_of_packet;
    logic [RINDEX_W-1:0] read_index;

    modport source (output valid, command, data_byte, end_of_packet, read_index,
                    input ready);
    modport sink   (input valid, command, data_byte, end_of_packet, read_index,
                    output ready);
endinterface

interface xpfec_res_if
    import xpfec_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              parity_ready;
    logic [BYTE_W-1:0] parity_byte;

    modport source (output valid, parity_ready, parity_byte, input ready);
    modport sink   (input valid, parity_ready, parity_byte, output ready);
endinterface

interface xpfec_cfg_if
    import xpfec_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

[rtl/core/xpfec_ram.sv]
// ----------------------------------------------------------------------------
// xpfec_ram
// Generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module xpfec_ram
    import xpfec_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/xor_parity_fec_encoder_top.sv]
// ----------------------------------------------------------------------------
// xor_parity_fec_encoder_top
// XOR parity generator for packet-level forward error correction
//
// Channels: request (command, data_byte, end_of_packet, read_index),
// result (parity_ready, parity_byte) and cfg (addr, data), all valid/ready.
// Every request gives exactly one result. Data bytes are XORed into a
// parity ram at their packet position; read requests return one parity
// byte; a clear request zeroes the whole ram.
// Data and read requests: the accept in ST_IDLE issues the ram read; in
// ST_EXEC, once the output register is free, a data byte is XORed back
// into the ram and the result register is loaded. No new request is taken
// before the block is back in ST_IDLE; the single ram read port and the
// read-modify-write on it are why. A clear request sweeps the ram one
// entry a cycle, then gives its result. After reset the same sweep runs
// before the first request is taken; cfg writes are taken at all times.
// A result waits in its output register while the receiver stalls; a
// request may still be accepted, and its write-back waits for the slot.
// ----------------------------------------------------------------------------
module xor_parity_fec_encoder_top
    import xpfec_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int MAX_GROUP   = MAX_GROUP_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    xpfec_cfg_if.sink   cfg,
    xpfec_req_if.sink   request,
    xpfec_res_if.source result
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int POS_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int SEEN_W = $clog2(MAX_GROUP);
    localparam int GRP_W  = $clog2(MAX_GROUP + 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic                     clr_cmd_reg;

    logic                     enable_reg;
    logic [GROUP_REG_W-1:0]   group_reg;
    logic [PAYLD_REG_W-1:0]   payload_reg;

    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [SEEN_W-1:0]        seen_reg, seen_next;

    cmd_t                     cmd_reg;
    logic [BYTE_W-1:0]        data_reg;
    logic                     eop_reg;
    logic                     rd_ok_reg;

    logic                     out_valid_reg;
    logic                     out_ready_reg, out_ready_next;
    logic [BYTE_W-1:0]        out_byte_reg, out_byte_next;

    logic [POS_W-1:0]         plen;
    logic [GRP_W-1:0]         glen;
    logic                     accept;
    logic                     fire;
    logic                     clr_last;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [BYTE_W-1:0]        wr_data;
    logic [ADDR_W-1:0]        rd_addr;
    logic [BYTE_W-1:0]        rd_data;

    // clamped payload length and group size
    assign plen = (payload_reg == '0) ? POS_W'(1) :
                  (32'(payload_reg) > 32'(MAX_PAYLOAD)) ? POS_W'(MAX_PAYLOAD) :
                  POS_W'(payload_reg);
    assign glen = (32'(group_reg) < 32'd2) ? GRP_W'(2) :
                  (32'(group_reg) > 32'(MAX_GROUP)) ? GRP_W'(MAX_GROUP) :
                  GRP_W'(group_reg);

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign fire          = (state_reg == ST_EXEC) && (!out_valid_reg || result.ready);
    assign clr_last      = (clr_cnt_reg == ADDR_W'(MAX_PAYLOAD - 1));

    assign cfg.ready     = 1'b1;

    assign result.valid        = out_valid_reg;
    assign result.parity_ready = out_ready_reg;
    assign result.parity_byte  = out_byte_reg;

    // ram read address chosen at accept
    assign rd_addr = (cmd_t'(request.command) == CMD_READ) ? ADDR_W'(request.read_index)
                                                           : ADDR_W'(pos_reg);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        out_ready_next = 1'b0;
        out_byte_next  = '0;
        wr_en          = 1'b0;
        wr_addr        = clr_cnt_reg;
        wr_data        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_last)
                begin
                    state_next = clr_cmd_reg ? ST_EXEC : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd_t'(request.command) == CMD_CLEAR) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                    case (cmd_reg)
                        CMD_DATA:
                        begin
                            if (enable_reg)
                            begin
                                if (32'(pos_reg) < 32'(plen))
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = ADDR_W'(pos_reg);
                                    wr_data = rd_data ^ data_reg;
                                end
                                if (32'(pos_reg) < 32'(MAX_PAYLOAD))
                                begin
                                    pos_next = pos_reg + POS_W'(1);
                                end
                                if (eop_reg)
                                begin
                                    pos_next = '0;
                                    if (32'(seen_reg) + 32'd1 >= 32'(glen))
                                    begin
                                        seen_next      = '0;
                                        out_ready_next = 1'b1;
                                    end
                                    else
                                    begin
                                        seen_next = seen_reg + SEEN_W'(1);
                                    end
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            out_byte_next = rd_ok_reg ? rd_data : '0;
                        end
                        default:
                        begin
                            out_byte_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_cmd_reg   <= 1'b0;
            enable_reg    <= 1'b0;
            group_reg     <= GROUP_RST;
            payload_reg   <= PAYLD_RST;
            pos_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;

            // clear sweep
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + ADDR_W'(1);
            end
            if (accept)
            begin
                clr_cmd_reg <= (cmd_t'(request.command) == CMD_CLEAR);
            end

            // configuration registers
            if (cfg.valid && cfg.ready)
            begin
                case (reg_idx_t'(cfg.addr))
                    REG_ENABLE:  enable_reg  <= cfg.data[0];
                    REG_GROUP:   group_reg   <= cfg.data[GROUP_REG_W-1:0];
                    REG_PAYLOAD: payload_reg <= cfg.data[PAYLD_REG_W-1:0];
                    default:     ;
                endcase
            end

            // output register
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(request.command);
            data_reg  <= request.data_byte;
            eop_reg   <= request.end_of_packet;
            rd_ok_reg <= (32'(request.read_index) < 32'(plen));
        end
        if (fire)
        begin
            out_ready_reg <= out_ready_next;
            out_byte_reg  <= out_byte_next;
        end
    end

    xpfec_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_parity_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
